// ----- hw/rtl/pmi_pkg.sv -----
// Shared types and constants for the pump motor interlock.
`timescale 1ns / 1ps

package pmi_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned DATA_W    = 16;

	localparam logic signed [DATA_W-1:0] MAX_TEMP_RST     = 16'sd600;
	localparam logic signed [DATA_W-1:0] MIN_LEVEL_RST    = 16'sd20;
	localparam logic signed [DATA_W-1:0] MIN_ON_LEVEL_RST = 16'sd40;
	localparam logic        [DATA_W-1:0] FLOW_TIMEOUT_RST = 16'd2000;
	localparam logic signed [DATA_W-1:0] LEVEL_RST        = 16'sd100;
	localparam logic signed [DATA_W-1:0] TEMP_RST         = 16'sd300;
	localparam logic        [DATA_W-1:0] MS_MAX           = 16'hFFFF;

	typedef enum logic [2:0] {
		CMD_OVERLOAD = 3'd0,
		CMD_LEVEL    = 3'd1,
		CMD_FLOW     = 3'd2,
		CMD_RESET    = 3'd3,
		CMD_ON       = 3'd4,
		CMD_OFF      = 3'd5,
		CMD_TEMP     = 3'd6,
		CMD_TICK     = 3'd7
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_TEMP     = 3'd0,
		REG_MIN_LEVEL    = 3'd1,
		REG_MIN_ON_LEVEL = 3'd2,
		REG_FLOW_TIMEOUT = 3'd3
	} cfg_idx_t;

	typedef struct packed {
		cmd_t                     command;
		logic signed [DATA_W-1:0] value;
		logic                     flag;
	} pmi_in_t;

	typedef struct packed {
		logic motor_drive;
		logic level_good;
		logic flow_ok;
	} pmi_out_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] trip_temp;
		logic signed [DATA_W-1:0] min_level;
		logic signed [DATA_W-1:0] min_on_level;
		logic        [DATA_W-1:0] flow_timeout_ms;
	} pmi_cfg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] water_level;
		logic signed [DATA_W-1:0] motor_temp;
		logic                     overload;
		logic                     run_request;
		logic                     level_ok;
		logic                     dry_fault;
		logic                     drive;
		logic        [DATA_W-1:0] ms_since_change;
	} pmi_state_t;

endpackage

// ----- hw/rtl/pmi_cfg_regs.sv -----
// Configuration register file of the pump motor interlock.
`timescale 1ns / 1ps

module pmi_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [pmi_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [pmi_pkg::DATA_W-1:0]      wr_data,
	output pmi_pkg::pmi_cfg_t               cfg
);

	pmi_pkg::pmi_cfg_t cfg_q;

	// Decode the index and store the write; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trip_temp       <= pmi_pkg::MAX_TEMP_RST;
			cfg_q.min_level       <= pmi_pkg::MIN_LEVEL_RST;
			cfg_q.min_on_level    <= pmi_pkg::MIN_ON_LEVEL_RST;
			cfg_q.flow_timeout_ms <= pmi_pkg::FLOW_TIMEOUT_RST;
		end else if (wr_en) begin
			unique case (pmi_pkg::cfg_idx_t'(wr_index))
				pmi_pkg::REG_MAX_TEMP:     cfg_q.trip_temp       <= wr_data;
				pmi_pkg::REG_MIN_LEVEL:    cfg_q.min_level       <= wr_data;
				pmi_pkg::REG_MIN_ON_LEVEL: cfg_q.min_on_level    <= wr_data;
				pmi_pkg::REG_FLOW_TIMEOUT: cfg_q.flow_timeout_ms <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/pmi_core.sv -----
// Interlock state and per-event update logic of the pump motor interlock.
`timescale 1ns / 1ps

module pmi_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  pmi_pkg::pmi_in_t    item,
	input  pmi_pkg::pmi_cfg_t   cfg,
	output pmi_pkg::pmi_out_t   result
);

	pmi_pkg::pmi_state_t st_q;
	pmi_pkg::pmi_state_t st_d;

	// Permit check: follow the run request when all interlocks are clear, else force off
	function automatic pmi_pkg::pmi_state_t try_drive(input pmi_pkg::pmi_state_t s,
			input pmi_pkg::pmi_cfg_t c);
		pmi_pkg::pmi_state_t r;
		r = s;
		if ((s.motor_temp >= c.trip_temp) || (s.water_level <= c.min_level) ||
				s.dry_fault || s.overload || !s.level_ok) begin
			r.drive = 1'b0;
		end else begin
			if (s.drive != s.run_request)
				r.ms_since_change = '0;
			r.drive = s.run_request;
		end
		return r;
	endfunction

	// Apply one event to the current state
	always_comb begin
		st_d = st_q;
		case (item.command)
			pmi_pkg::CMD_OVERLOAD: begin
				st_d.overload = item.flag;
				if (!item.flag)
					st_d = try_drive(st_d, cfg);
				if (st_d.run_request && item.flag)
					st_d.drive = 1'b0;
			end
			pmi_pkg::CMD_LEVEL: begin
				st_d.water_level = item.value;
				if (item.value >= cfg.min_on_level) begin
					st_d.level_ok = 1'b1;
					st_d = try_drive(st_d, cfg);
				end
				if (st_d.run_request && (item.value <= cfg.min_level)) begin
					st_d.level_ok = 1'b0;
					st_d.drive    = 1'b0;
				end
			end
			pmi_pkg::CMD_FLOW: begin
				if (st_d.drive && (item.value == '0) &&
						(st_d.ms_since_change > cfg.flow_timeout_ms)) begin
					st_d.dry_fault = 1'b1;
					st_d = try_drive(st_d, cfg);
				end
			end
			pmi_pkg::CMD_RESET: begin
				st_d.dry_fault = 1'b0;
				st_d = try_drive(st_d, cfg);
			end
			pmi_pkg::CMD_ON: begin
				st_d.run_request = 1'b1;
				st_d = try_drive(st_d, cfg);
			end
			pmi_pkg::CMD_OFF: begin
				st_d.run_request = 1'b0;
				st_d.drive       = 1'b0;
			end
			pmi_pkg::CMD_TEMP: begin
				st_d.motor_temp = item.value;
				if (item.value >= cfg.trip_temp)
					st_d.drive = 1'b0;
				else
					st_d = try_drive(st_d, cfg);
			end
			default: begin
				// tick: count up, saturate at the top
				if (st_d.ms_since_change != pmi_pkg::MS_MAX)
					st_d.ms_since_change = st_d.ms_since_change + 16'd1;
			end
		endcase
	end

	// Commit the new state when the event leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.water_level     <= pmi_pkg::LEVEL_RST;
			st_q.motor_temp      <= pmi_pkg::TEMP_RST;
			st_q.overload        <= 1'b0;
			st_q.run_request     <= 1'b0;
			st_q.level_ok        <= 1'b1;
			st_q.dry_fault       <= 1'b0;
			st_q.drive           <= 1'b0;
			st_q.ms_since_change <= '0;
		end else if (fire) begin
			st_q <= st_d;
		end
	end

	assign result.motor_drive = st_d.drive;
	assign result.level_good  = st_d.level_ok;
	assign result.flow_ok     = !st_d.dry_fault;

	a_drive_needs_request: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.drive |-> st_q.run_request)
		else $error("drive on without a run request");

	a_drive_needs_clear: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.drive |-> (!st_q.dry_fault && st_q.level_ok && !st_q.overload))
		else $error("drive on while an interlock is active");

	a_state_holds_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(st_q))
		else $error("state changed without an event");

endmodule

// ----- hw/rtl/pump_motor_interlock_unit.sv -----
// Top level of the pump motor interlock: input register, update logic, result register.
// Usage:
//   Events enter on the in channel (in_valid, in_stall, in_data) and are
//   accepted at a clock edge with in_valid high and in_stall low. Each event
//   yields exactly one result on the out channel (out_valid, out_stall,
//   out_data) holding motor drive, level state and flow status after it.
//   Configuration is written on the cfg channel (cfg_valid, cfg_ready,
//   cfg_index, cfg_data); cfg_ready is always high. Index 0 max temperature,
//   1 min level, 2 min on level, 3 flow timeout; other indexes are ignored.
//   Write configuration only while no event is in flight.
//   An accepted event waits in the input register until the result register
//   is free, then its result is registered there and held until taken.
//   Throughput: one event per cycle while out_stall is low, set by the
//   single update stage between the input register and the result register.
//   Reset (arst_n low) empties both registers and loads the default state
//   and register values. While out_stall holds a waiting result, one more
//   event is taken into the input register, then in_stall rises.
`timescale 1ns / 1ps

module pump_motor_interlock_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  pmi_pkg::pmi_in_t                in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output pmi_pkg::pmi_out_t               out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pmi_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pmi_pkg::DATA_W-1:0]      cfg_data
);

	pmi_pkg::pmi_cfg_t cfg;
	pmi_pkg::pmi_in_t  item_s1;
	pmi_pkg::pmi_out_t result;
	pmi_pkg::pmi_out_t out_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              advance;
	logic              fire;
	logic              take;

	// Result register frees when empty or taken; input register frees when it moves on
	assign advance   = !valid_s2 || !out_stall;
	assign fire      = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign take      = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	pmi_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	pmi_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Input register: hold the request until it reaches the update stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			item_s1 <= in_data;
	end

	// Result register: load on fire, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			out_s2 <= result;
	end

	assign out_valid = valid_s2;
	assign out_data  = out_s2;

	a_drive_implies_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.motor_drive) |-> (out_data.flow_ok && out_data.level_good))
		else $error("drive reported on while fault or low level reported");

	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && valid_s1))
		else $error("input stalled with a free result register");

	a_fire_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid)
		else $error("processed request did not reach the result register");

endmodule
